// File: rtl/core/tcsg_pkg.sv
// Shared types, codes and constants for the thruster command safety gate.
package tcsg_pkg;

  localparam int MAX_THRUSTERS = 8;
  localparam int NUM_THRUSTERS_DEF = 8;

  localparam int PULSE_W = 16;
  localparam int LEVEL_W = 11;
  localparam int TIME_W = 16;
  localparam int AGE_W = 32;
  localparam int CMD_W = 2;
  localparam int FAULT_W = 2;
  localparam int CFG_ADDR_W = 2;

  // Stream data widths, padded to whole bytes
  localparam int IN_DATA_W = 168;
  localparam int OUT_DATA_W = 96;

  localparam logic [PULSE_W-1:0] PULSE_MIN = 16'd1100;
  localparam logic [PULSE_W-1:0] PULSE_MAX = 16'd1900;
  localparam logic [PULSE_W-1:0] PULSE_NEUTRAL = 16'd1500;
  localparam logic [LEVEL_W-1:0] LEVEL_NEUTRAL = 11'd1500;
  localparam logic [TIME_W-1:0] TIME_RESET = 16'd1000;

  // Item kinds
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_THRUST = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOW_BAT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_KILL = 2'd3;

  // Fault codes
  localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_TIMEOUT = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_UNSYNC = 2'd2;
  localparam logic [FAULT_W-1:0] FAULT_BAD_CMD = 2'd3;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_AGE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_UPDATE_TIMEOUT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DISABLE_TIME = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WAKEUP_DELAY = 2'd3;

  typedef logic [MAX_THRUSTERS-1:0][LEVEL_W-1:0] levels_t;

  localparam levels_t NEUTRAL_LEVELS = {MAX_THRUSTERS{LEVEL_NEUTRAL}};

  typedef struct packed {
    logic [TIME_W-1:0] max_age_ms;
    logic [TIME_W-1:0] update_timeout_ms;
    logic [TIME_W-1:0] disable_time_ms;
    logic [TIME_W-1:0] wakeup_delay_ms;
  } cfg_t;

  typedef struct packed {
    levels_t           levels;
    logic [TIME_W-1:0] watchdog_left;
    logic [TIME_W-1:0] holdoff_left;
    logic [TIME_W-1:0] wakeup_left;
    logic              kill_asserted;
    logic              low_battery;
  } gate_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]                        command;
    logic [MAX_THRUSTERS-1:0][PULSE_W-1:0]   pulses;
    logic signed [AGE_W-1:0]                 command_age_ms;
    logic                                    flag;
  } item_t;

endpackage

// File: rtl/core/tcsg_cfg_regs.sv
// Configuration register file of the thruster command safety gate.
module tcsg_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            we,
  input  logic [tcsg_pkg::CFG_ADDR_W-1:0] addr,
  input  logic [tcsg_pkg::TIME_W-1:0]     wdata,
  output tcsg_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_age_ms        <= tcsg_pkg::TIME_RESET;
      cfg.update_timeout_ms <= tcsg_pkg::TIME_RESET;
      cfg.disable_time_ms   <= tcsg_pkg::TIME_RESET;
      cfg.wakeup_delay_ms   <= tcsg_pkg::TIME_RESET;
    end else if (we) begin
      case (addr)
        tcsg_pkg::REG_MAX_AGE:        cfg.max_age_ms        <= wdata;
        tcsg_pkg::REG_UPDATE_TIMEOUT: cfg.update_timeout_ms <= wdata;
        tcsg_pkg::REG_DISABLE_TIME:   cfg.disable_time_ms   <= wdata;
        tcsg_pkg::REG_WAKEUP_DELAY:   cfg.wakeup_delay_ms   <= wdata;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/tcsg_gate.sv
// Next-state and fault logic for one item of the thruster command safety gate.
module tcsg_gate #(
  parameter int NUM_THRUSTERS = tcsg_pkg::NUM_THRUSTERS_DEF
) (
  input  tcsg_pkg::cfg_t                cfg,
  input  tcsg_pkg::gate_state_t         st,
  input  tcsg_pkg::item_t               item,
  output tcsg_pkg::gate_state_t         st_next,
  output logic [tcsg_pkg::FAULT_W-1:0]  fault
);

  logic                                any_bad;
  logic                                active;
  logic                                age_ok;
  logic signed [tcsg_pkg::AGE_W:0]     age_ext;
  logic signed [tcsg_pkg::AGE_W:0]     age_lim;
  logic [tcsg_pkg::TIME_W-1:0]         arm_value;

  // Age window check at full signed width
  assign age_ext = {item.command_age_ms[tcsg_pkg::AGE_W-1], item.command_age_ms};
  assign age_lim = $signed({{(tcsg_pkg::AGE_W + 1 - tcsg_pkg::TIME_W){1'b0}}, cfg.max_age_ms});
  assign age_ok  = !(age_ext > age_lim) && !(age_ext < -age_lim);

  // A zero timeout still arms for one tick
  assign arm_value = (cfg.update_timeout_ms != '0) ? cfg.update_timeout_ms
                                                   : tcsg_pkg::TIME_W'(1);

  // Range check and activity over the used thrusters only
  always_comb begin
    any_bad = 1'b0;
    active  = 1'b0;
    for (int i = 0; i < tcsg_pkg::MAX_THRUSTERS; i++) begin
      if (i < NUM_THRUSTERS) begin
        if (item.pulses[i] < tcsg_pkg::PULSE_MIN || item.pulses[i] > tcsg_pkg::PULSE_MAX) begin
          any_bad = 1'b1;
        end
        if (item.pulses[i] != tcsg_pkg::PULSE_NEUTRAL) begin
          active = 1'b1;
        end
      end
    end
  end

  always_comb begin
    st_next = st;
    fault   = tcsg_pkg::FAULT_NONE;
    case (item.command)
      tcsg_pkg::CMD_TICK: begin
        if (st.holdoff_left != '0) begin
          st_next.holdoff_left = st.holdoff_left - tcsg_pkg::TIME_W'(1);
        end
        if (st.wakeup_left != '0) begin
          st_next.wakeup_left = st.wakeup_left - tcsg_pkg::TIME_W'(1);
        end
        if (st.watchdog_left != '0) begin
          st_next.watchdog_left = st.watchdog_left - tcsg_pkg::TIME_W'(1);
          // Expiry: drop to neutral and start hold-off
          if (st.watchdog_left == tcsg_pkg::TIME_W'(1)) begin
            st_next.levels       = tcsg_pkg::NEUTRAL_LEVELS;
            st_next.holdoff_left = cfg.disable_time_ms;
            fault                = tcsg_pkg::FAULT_TIMEOUT;
          end
        end
      end
      tcsg_pkg::CMD_THRUST: begin
        if (st.kill_asserted) begin
          fault = tcsg_pkg::FAULT_NONE;
        end else if (!item.flag) begin
          fault = tcsg_pkg::FAULT_UNSYNC;
        end else if (!age_ok) begin
          fault = tcsg_pkg::FAULT_BAD_CMD;
        end else begin
          st_next.watchdog_left = '0;
          if (st.holdoff_left != '0 || st.wakeup_left != '0 || st.low_battery) begin
            fault = tcsg_pkg::FAULT_NONE;
          end else if (any_bad) begin
            st_next.levels = tcsg_pkg::NEUTRAL_LEVELS;
            fault          = tcsg_pkg::FAULT_BAD_CMD;
          end else begin
            for (int i = 0; i < tcsg_pkg::MAX_THRUSTERS; i++) begin
              if (i < NUM_THRUSTERS) begin
                st_next.levels[i] = item.pulses[i][tcsg_pkg::LEVEL_W-1:0];
              end
            end
            if (active) begin
              st_next.watchdog_left = arm_value;
            end
          end
        end
      end
      tcsg_pkg::CMD_LOW_BAT: begin
        st_next.low_battery = item.flag;
        if (item.flag) begin
          st_next.levels        = tcsg_pkg::NEUTRAL_LEVELS;
          st_next.watchdog_left = '0;
        end
      end
      default: begin
        st_next.kill_asserted = item.flag;
        st_next.wakeup_left   = cfg.wakeup_delay_ms;
        if (item.flag) begin
          st_next.levels        = tcsg_pkg::NEUTRAL_LEVELS;
          st_next.watchdog_left = '0;
        end
      end
    endcase
  end

endmodule

// File: rtl/core/thruster_command_safety_gate_core.sv
// Top level of the thruster command safety gate.
//
// The gate holds eight thruster pulse-width levels and decides, item by item,
// whether a host command may reach them. Each accepted input transfer (a 1 ms
// tick, a thruster command, a low-battery change or a kill change, selected by
// s_tuser) yields exactly one output transfer carrying all eight levels after
// the item plus a fault code. Items flow in two register stages: an input
// register, then the gate logic, which updates the safety state and loads the
// output register in the same cycle. One item is taken every cycle while the
// output is not held by m_tready. The input side keeps accepting while a
// result waits on m_tready, until both stages are full. Configuration
// registers are written through cfg_we/cfg_addr/cfg_wdata and must only be
// changed while no item is in flight.
module thruster_command_safety_gate_core #(
  parameter int NUM_THRUSTERS = tcsg_pkg::NUM_THRUSTERS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // pulse_0..pulse_7 (16 each), command_age_ms (32), flag (1), zero pad
  input  logic [tcsg_pkg::IN_DATA_W-1:0]     s_tdata,
  // command (2)
  input  logic [tcsg_pkg::CMD_W-1:0]         s_tuser,
  // Result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // level_0..level_7 (11 each), fault (2), zero pad
  output logic [tcsg_pkg::OUT_DATA_W-1:0]    m_tdata,
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [tcsg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [tcsg_pkg::TIME_W-1:0]        cfg_wdata
);

  localparam int PULSES_W = tcsg_pkg::MAX_THRUSTERS * tcsg_pkg::PULSE_W;
  localparam int LEVELS_W = tcsg_pkg::MAX_THRUSTERS * tcsg_pkg::LEVEL_W;

  tcsg_pkg::cfg_t                 cfg;
  tcsg_pkg::item_t                item;
  logic                           item_valid;
  tcsg_pkg::gate_state_t          st;
  tcsg_pkg::gate_state_t          st_next;
  logic [tcsg_pkg::FAULT_W-1:0]   fault_next;
  logic                           advance;
  logic                           s_xfer;

  tcsg_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .addr  (cfg_addr),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  // Advance the input stage when the output register is empty or draining
  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;
  assign s_xfer   = s_tvalid && s_tready;

  // Input register: control bit under reset, payload loaded on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_xfer) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      item.command        <= s_tuser;
      item.pulses         <= s_tdata[PULSES_W-1:0];
      item.command_age_ms <= $signed(s_tdata[PULSES_W +: tcsg_pkg::AGE_W]);
      item.flag           <= s_tdata[PULSES_W + tcsg_pkg::AGE_W];
    end
  end

  tcsg_gate #(
    .NUM_THRUSTERS (NUM_THRUSTERS)
  ) u_gate (
    .cfg     (cfg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .fault   (fault_next)
  );

  // Safety state: commit the item's effect as it moves to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.levels        <= tcsg_pkg::NEUTRAL_LEVELS;
      st.watchdog_left <= '0;
      st.holdoff_left  <= '0;
      st.wakeup_left   <= '0;
      st.kill_asserted <= 1'b0;
      st.low_battery   <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Output register: hold a result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {{(tcsg_pkg::OUT_DATA_W - LEVELS_W - tcsg_pkg::FAULT_W){1'b0}},
                  fault_next, st_next.levels};
    end
  end

endmodule
